### design/iugf_pkg.sv
`default_nettype none
package iugf_pkg;

  localparam int unsigned MAX_INTERVALS = 64;
  localparam int unsigned TIME_BITS     = 31;
  localparam int unsigned CNT_W         = $clog2(MAX_INTERVALS + 1);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_e;

  typedef struct packed {
    logic insert;
    logic shift;
    logic occupied;
    logic at_tail;
  } cell_ctrl_t;

  typedef struct packed {
    logic pop;
    logic finish;
    logic dropped;
  } sweep_ctrl_t;

endpackage
`default_nettype wire

### design/iugf_cell.sv
`default_nettype none
module iugf_cell
  import iugf_pkg::*;
(
  input  wire        clk_i,
  input  cell_ctrl_t ctrl_i,
  input  time_t      new_start_i,
  input  time_t      new_end_i,
  input  logic       left_gt_i,
  input  time_t      left_start_i,
  input  time_t      left_end_i,
  input  time_t      right_start_i,
  input  time_t      right_end_i,
  output logic       gt_o,
  output time_t      start_o,
  output time_t      end_o
);

  time_t start_q, start_d;
  time_t end_q, end_d;

  assign gt_o    = ctrl_i.occupied && (start_q > new_start_i);
  assign start_o = start_q;
  assign end_o   = end_q;

  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    if (ctrl_i.insert) begin
      if (left_gt_i) begin
        start_d = left_start_i;
        end_d   = left_end_i;
      end else if (gt_o || ctrl_i.at_tail) begin
        start_d = new_start_i;
        end_d   = new_end_i;
      end
    end else if (ctrl_i.shift) begin
      start_d = right_start_i;
      end_d   = right_end_i;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
  end

endmodule
`default_nettype wire

### design/iugf_sweep.sv
`default_nettype none
module iugf_sweep
  import iugf_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  sweep_ctrl_t ctrl_i,
  input  time_t       head_start_i,
  input  time_t       head_end_i,
  output logic        strobe_o,
  output time_t       gap_start_o,
  output time_t       gap_end_o,
  output logic        no_gap_o,
  output logic        dropped_o,
  output logic        last_gap_o
);

  logic  have_end_q, have_end_d;
  time_t cur_end_q, cur_end_d;
  logic  pend_q, pend_d;
  time_t pend_start_q, pend_start_d;
  time_t pend_end_q, pend_end_d;

  logic  strobe_q, strobe_d;
  time_t gs_q, gs_d;
  time_t ge_q, ge_d;
  logic  none_q, none_d;
  logic  drop_q, drop_d;
  logic  last_q, last_d;

  always_comb begin
    have_end_d   = have_end_q;
    cur_end_d    = cur_end_q;
    pend_d       = pend_q;
    pend_start_d = pend_start_q;
    pend_end_d   = pend_end_q;
    strobe_d     = 1'b0;
    gs_d         = gs_q;
    ge_d         = ge_q;
    none_d       = none_q;
    drop_d       = drop_q;
    last_d       = last_q;
    if (ctrl_i.pop) begin
      if (!have_end_q) begin
        have_end_d = 1'b1;
        cur_end_d  = head_end_i;
      end else begin
        if (head_start_i > cur_end_q) begin
          if (pend_q) begin
            strobe_d = 1'b1;
            gs_d     = pend_start_q;
            ge_d     = pend_end_q;
            none_d   = 1'b0;
            drop_d   = ctrl_i.dropped;
            last_d   = 1'b0;
          end
          pend_d       = 1'b1;
          pend_start_d = cur_end_q;
          pend_end_d   = head_start_i;
        end
        if (head_end_i > cur_end_q) begin
          cur_end_d = head_end_i;
        end
      end
    end else if (ctrl_i.finish) begin
      strobe_d   = 1'b1;
      drop_d     = ctrl_i.dropped;
      last_d     = 1'b1;
      none_d     = !pend_q;
      gs_d       = pend_q ? pend_start_q : '0;
      ge_d       = pend_q ? pend_end_q : '0;
      have_end_d = 1'b0;
      pend_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_end_q <= 1'b0;
      pend_q     <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      have_end_q <= have_end_d;
      pend_q     <= pend_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_end_q    <= cur_end_d;
    pend_start_q <= pend_start_d;
    pend_end_q   <= pend_end_d;
    gs_q         <= gs_d;
    ge_q         <= ge_d;
    none_q       <= none_d;
    drop_q       <= drop_d;
    last_q       <= last_d;
  end

  assign strobe_o    = strobe_q;
  assign gap_start_o = gs_q;
  assign gap_end_o   = ge_q;
  assign no_gap_o    = none_q;
  assign dropped_o   = drop_q;
  assign last_gap_o  = last_q;

endmodule
`default_nettype wire

### design/interval_union_gap_finder_top.sv
// interval union gap finder
//
// input channel: busy_start_i, busy_end_i and final_item_i are taken at a rising
// edge where start is high and busy is low. while idle one interval is taken
// every cycle; each one is placed in a row of compare-and-shift cells, kept
// sorted by start (equal starts keep arrival order). intervals with
// end <= start are ignored; a valid interval arriving with all cells full is
// dropped and flagged on every result of the run.
// after the transfer with final_item_i set, busy is high while the row
// shifts out toward the gap sweep, one interval a cycle. a gap is held
// until the next gap is found, then shown in the following cycle; the
// final result is shown in the first cycle after busy falls.
// results: each gap is shown for one cycle with strobe_o high, in ascending
// order; last_gap_o marks the final one. with no gap a single result with
// no_gap_o high and zero gap fields is shown. the receiver cannot stall.
// reset clears the fill count, the drop flag and the sequencer; cell
// contents are not cleared and are read only below the fill count.
`default_nettype none
module interval_union_gap_finder_top
  import iugf_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start,
  output logic                  busy,
  input  wire  [TIME_BITS-1:0]  busy_start_i,
  input  wire  [TIME_BITS-1:0]  busy_end_i,
  input  wire                   final_item_i,
  output logic                  strobe_o,
  output logic [TIME_BITS-1:0]  gap_start_o,
  output logic [TIME_BITS-1:0]  gap_end_o,
  output logic                  no_gap_o,
  output logic                  dropped_o,
  output logic                  last_gap_o
);

  state_e state_q, state_d;
  cnt_t   count_q, count_d;
  logic   ovf_q, ovf_d;

  logic accept, valid_iv, full, empty;
  logic insert, shift, finish;

  cell_ctrl_t  cell_ctrl [MAX_INTERVALS];
  sweep_ctrl_t sweep_ctrl;
  logic        gt        [MAX_INTERVALS];
  time_t       c_start   [MAX_INTERVALS];
  time_t       c_end     [MAX_INTERVALS];

  assign accept   = start && !busy;
  assign valid_iv = busy_end_i > busy_start_i;
  assign full     = count_q == cnt_t'(MAX_INTERVALS);
  assign empty    = count_q == '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && final_item_i) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (empty) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b0;
    insert = 1'b0;
    shift  = 1'b0;
    finish = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        insert = accept && valid_iv && !full;
      end
      ST_SWEEP: begin
        busy   = 1'b1;
        shift  = !empty;
        finish = empty;
      end
      default: busy = 1'b0;
    endcase
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (insert) begin
      count_d = count_q + cnt_t'(1);
    end else if (shift) begin
      count_d = count_q - cnt_t'(1);
    end
    if (accept && valid_iv && full) begin
      ovf_d = 1'b1;
    end else if (finish) begin
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    logic  left_gt;
    time_t left_start, left_end, right_start, right_end;

    assign cell_ctrl[i].insert   = insert;
    assign cell_ctrl[i].shift    = shift;
    assign cell_ctrl[i].occupied = cnt_t'(i) < count_q;
    assign cell_ctrl[i].at_tail  = cnt_t'(i) == count_q;

    if (i == 0) begin : g_head
      assign left_gt    = 1'b0;
      assign left_start = '0;
      assign left_end   = '0;
    end else begin : g_mid
      assign left_gt    = gt[i-1];
      assign left_start = c_start[i-1];
      assign left_end   = c_end[i-1];
    end

    if (i == MAX_INTERVALS - 1) begin : g_tail
      assign right_start = '0;
      assign right_end   = '0;
    end else begin : g_inner
      assign right_start = c_start[i+1];
      assign right_end   = c_end[i+1];
    end

    iugf_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl[i]),
      .new_start_i   (busy_start_i),
      .new_end_i     (busy_end_i),
      .left_gt_i     (left_gt),
      .left_start_i  (left_start),
      .left_end_i    (left_end),
      .right_start_i (right_start),
      .right_end_i   (right_end),
      .gt_o          (gt[i]),
      .start_o       (c_start[i]),
      .end_o         (c_end[i])
    );
  end

  assign sweep_ctrl.pop     = shift;
  assign sweep_ctrl.finish  = finish;
  assign sweep_ctrl.dropped = ovf_q;

  iugf_sweep u_sweep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (sweep_ctrl),
    .head_start_i (c_start[0]),
    .head_end_i   (c_end[0]),
    .strobe_o     (strobe_o),
    .gap_start_o  (gap_start_o),
    .gap_end_o    (gap_end_o),
    .no_gap_o     (no_gap_o),
    .dropped_o    (dropped_o),
    .last_gap_o   (last_gap_o)
  );

endmodule
`default_nettype wire

### design/iugf_checker.sv
`default_nettype none
module iugf_checker
  import iugf_pkg::*;
(
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  start,
  input wire                  busy,
  input wire                  final_item_i,
  input wire                  strobe_o,
  input wire [TIME_BITS-1:0]  gap_start_o,
  input wire [TIME_BITS-1:0]  gap_end_o,
  input wire                  no_gap_o,
  input wire                  last_gap_o
);

  a_final_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && final_item_i |=> busy)
    else $error("final transfer did not start the sweep");

  a_last_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_gap_o |=> !strobe_o)
    else $error("result after the last one of a run");

  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && no_gap_o |-> last_gap_o && gap_start_o == '0 && gap_end_o == '0)
    else $error("malformed none result");

  a_gap_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !no_gap_o |-> gap_end_o > gap_start_o)
    else $error("gap of zero or negative length");

endmodule

bind interval_union_gap_finder_top iugf_checker u_iugf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .final_item_i (final_item_i),
  .strobe_o     (strobe_o),
  .gap_start_o  (gap_start_o),
  .gap_end_o    (gap_end_o),
  .no_gap_o     (no_gap_o),
  .last_gap_o   (last_gap_o)
);
`default_nettype wire
